FILE: rtl/core/stc_pkg.sv
// Shared types and constants for the T=0 exchange tracker.
// Holds phase and verdict codes, protocol byte values and the INS/P1 direction table.
package stc_pkg;

   localparam int ByteWidth    = 8;
   localparam int LengthWidth  = 9;
   localparam int CountWidth   = 3;

   localparam logic [7:0] NullByte    = 8'h60;
   localparam logic [3:0] Sw1HighSix  = 4'h6;
   localparam logic [3:0] Sw1HighNine = 4'h9;
   localparam logic [7:0] InvertMask  = 8'hFF;
   localparam logic [7:0] InsSelect   = 8'hA4;
   localparam logic [LengthWidth-1:0] MaxLength = 9'd256;

   localparam logic [CountWidth-1:0] HdrInsIdx = 3'd2;
   localparam logic [CountWidth-1:0] HdrP1Idx  = 3'd3;
   localparam logic [CountWidth-1:0] HdrLenIdx = 3'd5;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_PROC   = 3'd1,
      PH_SW2    = 3'd2,
      PH_ALL    = 3'd3,
      PH_ONE    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      V_CONT      = 2'd0,
      V_TO_CARD   = 2'd1,
      V_FROM_CARD = 2'd2,
      V_UNKNOWN   = 2'd3
   } verdict_type;

   // Direction of the data phase, looked up from INS and (for SELECT) P1
   function automatic verdict_type direction_of(input logic [7:0] ins, input logic [7:0] p1);
      verdict_type dir;
      dir = V_UNKNOWN;
      unique case (ins)
         8'h04, 8'h0E, 8'h0F, 8'h20, 8'h21, 8'h22, 8'h24, 8'h26, 8'h28, 8'h2C,
         8'h44, 8'h82, 8'h86, 8'h87, 8'h88, 8'hA1, 8'hA2, 8'hB1, 8'hB3, 8'hC2,
         8'hC3, 8'hCB, 8'hD0, 8'hD1, 8'hD2, 8'hD6, 8'hD7, 8'hDA, 8'hDB, 8'hDC,
         8'hDD, 8'hE0, 8'hE2, 8'hE4: dir = V_TO_CARD;
         8'h70, 8'h84, 8'hB0, 8'hB2, 8'hC0, 8'hCA: dir = V_FROM_CARD;
         InsSelect: begin
            unique case (p1)
               8'h01, 8'h02, 8'h04, 8'h08, 8'h09: dir = V_TO_CARD;
               8'h03:                             dir = V_FROM_CARD;
               default:                           dir = V_UNKNOWN;
            endcase
         end
         default: dir = V_UNKNOWN;
      endcase
      return dir;
   endfunction

endpackage

FILE: rtl/core/smartcard_t0_exchange_tracker_core.sv
// T=0 exchange tracker: one card I/O line byte per req beat, one verdict per rsp beat.
// A byte is registered on input, decoded against the tracker state while it is held there, and
// its verdict registered on output; one byte per cycle is sustained while rsp_tready is high.
// Verdict: 0 continue, 1 packet to card ends, 2 packet from card ends, 3 unknown direction.
// Depends on stc_pkg and stc_tracker.
module smartcard_t0_exchange_tracker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] line_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] verdict, [7:2] zero
);
   import stc_pkg::*;

   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff;
   verdict_type          out_verdict_ff;
   verdict_type          step_verdict;
   logic                 advance;

   // a byte moves to the output register when that register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   stc_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .line_byte (in_byte_ff),
      .verdict   (step_verdict)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) out_verdict_ff <= step_verdict;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_verdict_ff};

endmodule

FILE: rtl/core/stc_tracker.sv
// Exchange state of the T=0 tracker: header capture, procedure decode, data count.
// Updates once per enabled byte and returns that byte's verdict; uses stc_pkg.
module stc_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic [stc_pkg::ByteWidth-1:0] line_byte,
   output stc_pkg::verdict_type        verdict
);
   import stc_pkg::*;

   phase_type              phase_ff,  phase_in;
   logic [CountWidth-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [ByteWidth-1:0]   ins_ff,    ins_in;
   logic [ByteWidth-1:0]   p1_ff,     p1_in;
   logic [LengthWidth-1:0] exp_len_ff, exp_len_in;
   logic [LengthWidth-1:0] xfer_cnt_ff, xfer_cnt_in;

   logic [CountWidth-1:0]  hdr_cnt_inc;
   logic [LengthWidth-1:0] xfer_cnt_inc;
   logic                   more_left;
   logic                   status_class;
   verdict_type            dir;

   assign hdr_cnt_inc  = hdr_cnt_ff + CountWidth'(1);
   assign xfer_cnt_inc = xfer_cnt_ff + LengthWidth'(1);
   assign more_left    = xfer_cnt_ff < exp_len_ff;
   assign status_class = (line_byte[7:4] == Sw1HighSix) || (line_byte[7:4] == Sw1HighNine);
   assign dir          = direction_of(ins_ff, p1_ff);

   // Next state and verdict for one byte
   always_comb begin
      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      ins_in      = ins_ff;
      p1_in       = p1_ff;
      exp_len_in  = exp_len_ff;
      xfer_cnt_in = xfer_cnt_ff;
      verdict     = V_CONT;
      unique case (phase_ff)
         PH_PROC: begin
            if (line_byte == NullByte) begin
               verdict = V_FROM_CARD;
            end else begin
               if (status_class) phase_in = PH_SW2;
               if (line_byte == ins_ff) begin
                  if (more_left) phase_in = PH_ALL;
                  verdict = V_FROM_CARD;
               end else if ((line_byte ^ InvertMask) == ins_ff) begin
                  if (more_left) phase_in = PH_ONE;
                  verdict = V_FROM_CARD;
               end
            end
         end
         PH_SW2: begin
            phase_in    = PH_HEADER;
            hdr_cnt_in  = '0;
            xfer_cnt_in = '0;
            verdict     = V_FROM_CARD;
         end
         PH_ALL: begin
            xfer_cnt_in = xfer_cnt_inc;
            if (xfer_cnt_inc == exp_len_ff) begin
               phase_in = PH_PROC;
               verdict  = dir;
            end
         end
         PH_ONE: begin
            xfer_cnt_in = xfer_cnt_inc;
            phase_in    = PH_PROC;
            verdict     = dir;
         end
         default: begin
            // header phase: CLA INS P1 P2 P3
            hdr_cnt_in = hdr_cnt_inc;
            if (hdr_cnt_inc == HdrInsIdx) begin
               ins_in = line_byte;
            end else if (hdr_cnt_inc == HdrP1Idx) begin
               p1_in = line_byte;
            end else if (hdr_cnt_inc == HdrLenIdx) begin
               // a zero length means 256 only for reads from the card
               if (line_byte == '0 && dir == V_FROM_CARD) exp_len_in = MaxLength;
               else                                       exp_len_in = {1'b0, line_byte};
               phase_in = PH_PROC;
               verdict  = V_TO_CARD;
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_cnt_ff  <= '0;
         ins_ff      <= '0;
         p1_ff       <= '0;
         exp_len_ff  <= '0;
         xfer_cnt_ff <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         ins_ff      <= ins_in;
         p1_ff       <= p1_in;
         exp_len_ff  <= exp_len_in;
         xfer_cnt_ff <= xfer_cnt_in;
      end
   end

endmodule
